[rtl/bcd_calendar_register_codec_assert.svh]
// ----------------------------------------------------------------------------
// BCD calendar codec assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef BCD_CALENDAR_REGISTER_CODEC_ASSERT_SVH
`define BCD_CALENDAR_REGISTER_CODEC_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BCDC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define BCDC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BCDC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define BCDC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[rtl/bcdc_pkg.sv]
// ----------------------------------------------------------------------------
// bcdc_pkg
// Types, constants and small conversion functions of the BCD calendar codec.
// ----------------------------------------------------------------------------
package bcdc_pkg;

  localparam logic [13:0] BaseReset  = 14'd2000;
  localparam logic        ReqEncode  = 1'b0;
  localparam logic        StatusOk   = 1'b0;
  localparam logic        StatusErr  = 1'b1;

  // Input item
  typedef struct packed {
    logic        req_type;
    logic [7:0]  in_second;
    logic [7:0]  in_minute;
    logic [7:0]  in_hour;
    logic [7:0]  in_day;
    logic [7:0]  in_weekday;
    logic [7:0]  in_month;
    logic [15:0] in_year;
    logic [55:0] in_image;
  } req_t;

  // Result item
  typedef struct packed {
    logic        status;
    logic [55:0] out_image;
    logic [6:0]  out_second;
    logic [6:0]  out_minute;
    logic [5:0]  out_hour;
    logic [5:0]  out_day;
    logic [2:0]  out_weekday;
    logic [4:0]  out_month;
    logic [13:0] out_year;
    logic        voltage_low_flag;
    logic        century_flag;
  } rsp_t;

  // Decoded fields, shared by both inner stages
  typedef struct packed {
    logic [6:0] sec;
    logic [6:0] min;
    logic [5:0] hour;
    logic [5:0] day;
    logic [2:0] wday;
    logic [4:0] mon;
    logic       vl;
    logic       cent;
  } dec_t;

  // Check stage -> reduce stage
  typedef struct packed {
    logic       req_type;
    logic       range_ok;
    logic [7:0] off;
    logic [4:0] dim;
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [7:0] day;
    logic [2:0] wday;
    logic [3:0] mon;
    dec_t       dec;
    logic [7:0] year_byte;
  } stg_a_t;

  // Reduce stage -> pack stage
  typedef struct packed {
    logic        req_type;
    logic        ok;
    logic        cent_e;
    logic [6:0]  off2;
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [2:0]  wday;
    logic [3:0]  mon;
    dec_t        dec;
    logic [13:0] d_year;
  } stg_b_t;

  // Two BCD digits to binary, digits unchecked
  function automatic logic [7:0] bcdc_from_bcd(input logic [7:0] b);
    logic [7:0] hi;
    hi = {4'd0, b[7:4]};
    return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
  endfunction

  // Binary below 100 to two BCD digits; tens by reciprocal multiply
  function automatic logic [7:0] bcdc_to_bcd(input logic [6:0] v);
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [6:0]  rem;
    prod = {7'd0, v} * 14'd103;
    tens = prod[13:10];
    rem  = v - ({3'd0, tens} << 3) - ({3'd0, tens} << 1);
    return {tens, rem[3:0]};
  endfunction

  // Month length, month 1..12; leap means year divisible by four
  function automatic logic [4:0] bcdc_days_in_month(input logic [3:0] mon,
                                                   input logic leap);
    logic [4:0] d;
    unique case (mon)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   d = 5'd30;
      4'd2:                                      d = leap ? 5'd29 : 5'd28;
      default:                                   d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

[rtl/bcdc_if.sv]
// ----------------------------------------------------------------------------
// bcdc_if
// Valid/ready channels of the BCD calendar codec: request, result, config.
// ----------------------------------------------------------------------------
interface bcdc_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  in_second;
  logic [7:0]  in_minute;
  logic [7:0]  in_hour;
  logic [7:0]  in_day;
  logic [7:0]  in_weekday;
  logic [7:0]  in_month;
  logic [15:0] in_year;
  logic [55:0] in_image;

  modport source (output valid, req_type, in_second, in_minute, in_hour, in_day,
                  in_weekday, in_month, in_year, in_image, input ready);
  modport sink   (input valid, req_type, in_second, in_minute, in_hour, in_day,
                  in_weekday, in_month, in_year, in_image, output ready);
endinterface

interface bcdc_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [55:0] out_image;
  logic [6:0]  out_second;
  logic [6:0]  out_minute;
  logic [5:0]  out_hour;
  logic [5:0]  out_day;
  logic [2:0]  out_weekday;
  logic [4:0]  out_month;
  logic [13:0] out_year;
  logic        voltage_low_flag;
  logic        century_flag;

  modport source (output valid, status, out_image, out_second, out_minute,
                  out_hour, out_day, out_weekday, out_month, out_year,
                  voltage_low_flag, century_flag, input ready);
  modport sink   (input valid, status, out_image, out_second, out_minute,
                  out_hour, out_day, out_weekday, out_month, out_year,
                  voltage_low_flag, century_flag, output ready);
endinterface

interface bcdc_cfg_if;
  logic        valid;
  logic        ready;
  logic [13:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[rtl/bcd_calendar_register_codec.sv]
// ----------------------------------------------------------------------------
// bcd_calendar_register_codec
// Binary calendar fields <-> seven-byte BCD clock register image.
//
//   channel  dir  modport  carries
//   req_i    in   sink     request item: req_type, fields, image
//   rsp_o    out  source   result item: status, image, decoded fields
//   cfg_i    in   sink     century_base write (14 bits), always ready
//
// Three register stages: check, reduce, pack. An accepted request is registered
// in check, then in reduce, then in pack, whose output register drives the
// result; one item per cycle is sustained while the result is taken.
// Ready is combinational through all three stages: a stage takes a new item
// when it is empty or its item moves on in the same cycle, so a stall drops or
// repeats nothing. With the result held off, req ready drops once all three
// stages are full. Reset empties all stages and sets century_base to 2000.
// ----------------------------------------------------------------------------
`include "bcd_calendar_register_codec_assert.svh"

module bcd_calendar_register_codec import bcdc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bcdc_req_if.sink   req_i,
  bcdc_rsp_if.source rsp_o,
  bcdc_cfg_if.sink   cfg_i
);

  logic [13:0] base_q;
  req_t        req;
  stg_a_t      a_data;
  stg_b_t      b_data;
  rsp_t        rsp;
  logic        a_vld, a_rdy, b_vld, b_rdy, c_vld;

  // Configuration register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BaseReset;
    end else if (cfg_i.valid) begin
      base_q <= cfg_i.data;
    end
  end

  // Request bundle
  always_comb begin
    req.req_type   = req_i.req_type;
    req.in_second  = req_i.in_second;
    req.in_minute  = req_i.in_minute;
    req.in_hour    = req_i.in_hour;
    req.in_day     = req_i.in_day;
    req.in_weekday = req_i.in_weekday;
    req.in_month   = req_i.in_month;
    req.in_year    = req_i.in_year;
    req.in_image   = req_i.in_image;
  end

  bcdc_check u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .base_i      (base_q),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .in_data_i   (req),
    .out_valid_o (a_vld),
    .out_ready_i (a_rdy),
    .out_data_o  (a_data)
  );

  bcdc_reduce u_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .base_i      (base_q),
    .in_valid_i  (a_vld),
    .in_ready_o  (a_rdy),
    .in_data_i   (a_data),
    .out_valid_o (b_vld),
    .out_ready_i (b_rdy),
    .out_data_o  (b_data)
  );

  bcdc_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (b_vld),
    .in_ready_o  (b_rdy),
    .in_data_i   (b_data),
    .out_valid_o (c_vld),
    .out_ready_i (rsp_o.ready),
    .out_data_o  (rsp)
  );

  // Result channel
  assign rsp_o.valid            = c_vld;
  assign rsp_o.status           = rsp.status;
  assign rsp_o.out_image        = rsp.out_image;
  assign rsp_o.out_second       = rsp.out_second;
  assign rsp_o.out_minute       = rsp.out_minute;
  assign rsp_o.out_hour         = rsp.out_hour;
  assign rsp_o.out_day          = rsp.out_day;
  assign rsp_o.out_weekday      = rsp.out_weekday;
  assign rsp_o.out_month        = rsp.out_month;
  assign rsp_o.out_year         = rsp.out_year;
  assign rsp_o.voltage_low_flag = rsp.voltage_low_flag;
  assign rsp_o.century_flag     = rsp.century_flag;

  // Checks
  `BCDC_ASSERT_IMP(a_err_zero_image, clk_i, rst_ni, c_vld && rsp.status == StatusErr, rsp.out_image == 56'd0, "error result with nonzero image")
  `BCDC_ASSERT_IMP(a_err_no_flags, clk_i, rst_ni, c_vld && rsp.status == StatusErr, !rsp.century_flag && !rsp.voltage_low_flag, "error result with decode flags")
  `BCDC_ASSERT_NXT(a_pack_from_reduce, clk_i, rst_ni, !c_vld && !b_vld, !c_vld, "output valid without a stage 2 item")

endmodule

[rtl/bcdc_check.sv]
// ----------------------------------------------------------------------------
// bcdc_check
// Stage 1: field range and year window checks, month length lookup,
// masked BCD decode of the image bytes.
// ----------------------------------------------------------------------------
module bcdc_check import bcdc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [13:0] base_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output stg_a_t      out_data_o
);

  logic        vld_q;
  stg_a_t      data_q, data_d;
  logic [16:0] year_x, base_x, diff;
  logic        in_win;
  logic [7:0]  b0_d, b1_d, b2_d, b3_d, b5_d;

  assign in_ready_o = !vld_q || out_ready_i;

  // Year window on full width
  always_comb begin
    year_x = {1'b0, in_data_i.in_year};
    base_x = {3'd0, base_i};
    diff   = year_x - base_x;
    in_win = (year_x >= base_x) && (year_x <= base_x + 17'd199);
  end

  // Masked BCD decode of image bytes 0, 1, 2, 3 and 5
  always_comb begin
    b0_d = bcdc_from_bcd({1'b0, in_data_i.in_image[6:0]});
    b1_d = bcdc_from_bcd({1'b0, in_data_i.in_image[14:8]});
    b2_d = bcdc_from_bcd({2'd0, in_data_i.in_image[21:16]});
    b3_d = bcdc_from_bcd({2'd0, in_data_i.in_image[29:24]});
    b5_d = bcdc_from_bcd({3'd0, in_data_i.in_image[44:40]});
  end

  always_comb begin
    data_d           = '0;
    data_d.req_type  = in_data_i.req_type;
    data_d.range_ok  = (in_data_i.in_second <= 8'd59) && (in_data_i.in_minute <= 8'd59) &&
                       (in_data_i.in_hour <= 8'd23) && (in_data_i.in_weekday <= 8'd6) &&
                       (in_data_i.in_month >= 8'd1) && (in_data_i.in_month <= 8'd12) &&
                       in_win;
    data_d.off       = diff[7:0];
    data_d.dim       = bcdc_days_in_month(in_data_i.in_month[3:0],
                                          in_data_i.in_year[1:0] == 2'd0);
    data_d.sec       = in_data_i.in_second[5:0];
    data_d.min       = in_data_i.in_minute[5:0];
    data_d.hour      = in_data_i.in_hour[4:0];
    data_d.day       = in_data_i.in_day;
    data_d.wday      = in_data_i.in_weekday[2:0];
    data_d.mon       = in_data_i.in_month[3:0];
    data_d.dec.sec   = b0_d[6:0];
    data_d.dec.min   = b1_d[6:0];
    data_d.dec.hour  = b2_d[5:0];
    data_d.dec.day   = b3_d[5:0];
    data_d.dec.wday  = in_data_i.in_image[34:32];
    data_d.dec.mon   = b5_d[4:0];
    data_d.dec.vl    = in_data_i.in_image[7];
    data_d.dec.cent  = in_data_i.in_image[47];
    data_d.year_byte = bcdc_from_bcd(in_data_i.in_image[55:48]);
  end

  // Stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  // Stage data
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

endmodule

[rtl/bcdc_reduce.sv]
// ----------------------------------------------------------------------------
// bcdc_reduce
// Stage 2: day-of-month check, century split of the year offset,
// decoded year sum.
// ----------------------------------------------------------------------------
module bcdc_reduce import bcdc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [13:0] base_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  stg_a_t      in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output stg_b_t      out_data_o
);

  logic   vld_q;
  stg_b_t data_q, data_d;
  logic   cent_e;
  logic [7:0] off_sub;

  assign in_ready_o = !vld_q || out_ready_i;

  always_comb begin
    cent_e  = in_data_i.off >= 8'd100;
    off_sub = cent_e ? (in_data_i.off - 8'd100) : in_data_i.off;

    data_d          = '0;
    data_d.req_type = in_data_i.req_type;
    data_d.ok       = in_data_i.range_ok && (in_data_i.day >= 8'd1) &&
                      (in_data_i.day <= {3'd0, in_data_i.dim});
    data_d.cent_e   = cent_e;
    data_d.off2     = off_sub[6:0];
    data_d.sec      = in_data_i.sec;
    data_d.min      = in_data_i.min;
    data_d.hour     = in_data_i.hour;
    data_d.day      = in_data_i.day[4:0];
    data_d.wday     = in_data_i.wday;
    data_d.mon      = in_data_i.mon;
    data_d.dec      = in_data_i.dec;
    // wraps to 14 bits
    data_d.d_year   = base_i + (in_data_i.dec.cent ? 14'd100 : 14'd0) +
                      {6'd0, in_data_i.year_byte};
  end

  // Stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  // Stage data
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

endmodule

[rtl/bcdc_pack.sv]
// ----------------------------------------------------------------------------
// bcdc_pack
// Stage 3: binary-to-BCD of the encode fields, image assembly and result
// selection into the output register.
// ----------------------------------------------------------------------------
module bcdc_pack import bcdc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  stg_b_t in_data_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output rsp_t   out_data_o
);

  logic       vld_q;
  rsp_t       data_q, data_d;
  logic [7:0] sec_b, min_b, hour_b, day_b, mon_b, year_b;

  assign in_ready_o = !vld_q || out_ready_i;

  // BCD conversion of the encode fields
  always_comb begin
    sec_b  = bcdc_to_bcd({1'b0, in_data_i.sec});
    min_b  = bcdc_to_bcd({1'b0, in_data_i.min});
    hour_b = bcdc_to_bcd({2'd0, in_data_i.hour});
    day_b  = bcdc_to_bcd({2'd0, in_data_i.day});
    mon_b  = bcdc_to_bcd({3'd0, in_data_i.mon});
    year_b = bcdc_to_bcd(in_data_i.off2);
  end

  // Result selection
  always_comb begin
    data_d = '0;
    if (in_data_i.req_type == ReqEncode) begin
      if (in_data_i.ok) begin
        data_d.status    = StatusOk;
        data_d.out_image = {year_b, in_data_i.cent_e, mon_b[6:0],
                            5'd0, in_data_i.wday, day_b, hour_b, min_b, sec_b};
      end else begin
        data_d.status    = StatusErr;
      end
    end else begin
      data_d.status           = StatusOk;
      data_d.out_second       = in_data_i.dec.sec;
      data_d.out_minute       = in_data_i.dec.min;
      data_d.out_hour         = in_data_i.dec.hour;
      data_d.out_day          = in_data_i.dec.day;
      data_d.out_weekday      = in_data_i.dec.wday;
      data_d.out_month        = in_data_i.dec.mon;
      data_d.out_year         = in_data_i.d_year;
      data_d.voltage_low_flag = in_data_i.dec.vl;
      data_d.century_flag     = in_data_i.dec.cent;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

endmodule
